FILE: hw/rtl/kpp_pkg.sv
// ----------------------------------------------------------------------------
// kpp_pkg
// Shared types and constants for the seed picker.
// ----------------------------------------------------------------------------
package kpp_pkg;

  localparam int unsigned MaxPoints   = 1024;
  localparam int unsigned MaxCentres  = 64;
  localparam int unsigned Dims        = 4;
  localparam int unsigned FeatureBits = 16;

  localparam int unsigned DistBits = 37;
  localparam int unsigned SumBits  = 64;

  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusNoPoints = 2'd1;
  localparam logic [1:0] StatusFull     = 2'd2;

  // Sequencer to distance unit.
  typedef struct packed {
    logic start;  // begin one squared-distance evaluation
  } dist_req_t;

endpackage

FILE: hw/rtl/kpp_dist.sv
// ----------------------------------------------------------------------------
// kpp_dist
// Shared squared-distance unit: one feature per cycle through one multiplier.
// ----------------------------------------------------------------------------
module kpp_dist #(
  parameter int unsigned Dims        = kpp_pkg::Dims,
  parameter int unsigned FeatureBits = kpp_pkg::FeatureBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  kpp_pkg::dist_req_t            req_i,
  input  logic [Dims*FeatureBits-1:0]   a_i,
  input  logic [Dims*FeatureBits-1:0]   b_i,
  output logic                          done_o,
  output logic [kpp_pkg::DistBits-1:0]  dist_o
);

  localparam int unsigned DimW  = (Dims > 1) ? $clog2(Dims) : 1;
  localparam int unsigned DiffW = FeatureBits + 1;
  localparam int unsigned SqW   = 2 * DiffW;
  localparam int unsigned AccW  = SqW + 4;
  localparam logic [AccW-1:0] Sat = AccW'({kpp_pkg::DistBits{1'b1}});

  logic            busy_q, busy_d;
  logic [DimW-1:0] dim_q, dim_d;
  logic [AccW-1:0] acc_q, acc_d;
  logic            done_q, done_d;

  logic signed [FeatureBits-1:0] fa, fb;
  logic signed [DiffW-1:0]       diff;
  logic        [DiffW-1:0]       mag;
  logic        [SqW-1:0]         sq;

  always_comb begin
    fa   = a_i[dim_q*FeatureBits +: FeatureBits];
    fb   = b_i[dim_q*FeatureBits +: FeatureBits];
    diff = DiffW'(fa) - DiffW'(fb);
    mag  = diff[DiffW-1] ? DiffW'(-diff) : DiffW'(diff);
    sq   = SqW'(mag) * SqW'(mag);
  end

  always_comb begin
    busy_d = busy_q;
    dim_d  = dim_q;
    acc_d  = acc_q;
    done_d = 1'b0;
    if (req_i.start) begin
      busy_d = 1'b1;
      dim_d  = '0;
      acc_d  = '0;
    end else if (busy_q) begin
      acc_d = acc_q + AccW'(sq);
      if (dim_q == DimW'(Dims - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        dim_d = dim_q + DimW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      dim_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      dim_q  <= dim_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign done_o = done_q;
  assign dist_o = (acc_q > Sat) ? kpp_pkg::DistBits'(Sat)
                                : kpp_pkg::DistBits'(acc_q);

endmodule

FILE: hw/rtl/kmeanspp_seed_picker_top.sv
// ----------------------------------------------------------------------------
// kmeanspp_seed_picker_top
// k-means++ seed selection over a stored point set, fixed point.
// ----------------------------------------------------------------------------
// A load transfer stores one point, unless the store is full: it is accepted
// in the idle state and written in the load state. A pick transfer takes the
// next seed centre: the first pick makes one multiply by the point count; each
// later pick makes two passes over the n stored points, the first in the
// shared squared-distance unit (one multiplier, one feature per cycle), the
// second a running-sum compare that may stop early and is skipped when the
// distance total is zero.
// The block holds in_ready_o low during that work.
// Refused picks (no points, or centres complete) return at once with status.
// The result sits in an output register; a new item is accepted only once
// that result is taken, at the earliest in the cycle of its output transfer.
// Point and distance stores are plain RAMs with no clearing pass.
// ----------------------------------------------------------------------------
module kmeanspp_seed_picker_top #(
  parameter int unsigned MaxPoints   = kpp_pkg::MaxPoints,
  parameter int unsigned MaxCentres  = kpp_pkg::MaxCentres,
  parameter int unsigned Dims        = kpp_pkg::Dims,
  parameter int unsigned FeatureBits = kpp_pkg::FeatureBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [6:0]  cfg_num_centres_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        op_i,
  input  logic        first_i,
  input  logic [15:0] point_f0_i,
  input  logic [15:0] point_f1_i,
  input  logic [15:0] point_f2_i,
  input  logic [15:0] point_f3_i,
  input  logic [15:0] rand_frac_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [9:0]  chosen_index_o,
  output logic [15:0] centre_f0_o,
  output logic [15:0] centre_f1_o,
  output logic [15:0] centre_f2_o,
  output logic [15:0] centre_f3_o
);

  localparam int unsigned FB   = (FeatureBits < 16) ? FeatureBits : 16;
  localparam int unsigned PW   = Dims * FB;
  localparam int unsigned AW   = $clog2(MaxPoints);
  localparam int unsigned CW   = AW + 1;
  localparam int unsigned KW   = $clog2(MaxCentres + 1) + 1;
  localparam int unsigned DB   = kpp_pkg::DistBits;
  localparam int unsigned SB   = kpp_pkg::SumBits;
  localparam logic [DB-1:0] DistMax = '1;

  typedef enum logic [9:0] {
    StIdle   = 10'b0000000001,
    StLoad   = 10'b0000000010,
    StFirst  = 10'b0000000100,
    StRd1    = 10'b0000001000,
    StDist   = 10'b0000010000,
    StUpd    = 10'b0000100000,
    StMul    = 10'b0001000000,
    StRd2    = 10'b0010000000,
    StCmp    = 10'b0100000000,
    StFetch  = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  logic [PW-1:0] pts_mem [MaxPoints];
  logic [DB-1:0] nd_mem  [MaxPoints];
  logic [PW-1:0] pt_rd_q;
  logic [DB-1:0] nd_rd_q;

  logic [CW-1:0] pcount_q, pcount_d;
  logic [KW-1:0] ccount_q, ccount_d;
  logic [6:0]    ncent_q;
  logic [PW-1:0] last_q, last_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [SB-1:0] total_q, total_d, sum_q, sum_d, target_q, target_d;
  logic [15:0]   rand_q, rand_d;
  logic [PW-1:0] ld_q, ld_d;
  logic [AW-1:0] pick_q, pick_d;
  logic          first_pick_q, first_pick_d;

  logic          ov_q, ov_d;
  logic [1:0]    st_q, st_d;
  logic [9:0]    ci_q, ci_d;
  logic [63:0]   cf_q, cf_d;

  logic          we_pt, we_nd;
  logic [AW-1:0] wa_pt, wa_nd, ra;
  logic [PW-1:0] wd_pt;
  logic [DB-1:0] wd_nd;

  kpp_pkg::dist_req_t    dreq;
  logic                  ddone;
  logic [DB-1:0]         ddist;

  logic [KW-1:0] limit;
  logic [15:0]   fin [4];
  logic [CW+15:0] fprod;
  logic [SB-1:0] nsum;
  logic [DB-1:0] newd;
  logic          in_acc, last_pt;

  kpp_dist #(.Dims(Dims), .FeatureBits(FB)) u_dist (
    .clk_i, .rst_ni, .req_i(dreq), .a_i(pt_rd_q), .b_i(last_q),
    .done_o(ddone), .dist_o(ddist)
  );

  assign fin[0] = point_f0_i;
  assign fin[1] = point_f1_i;
  assign fin[2] = point_f2_i;
  assign fin[3] = point_f3_i;

  assign in_ready_o  = (state_q == StIdle) && (!ov_q || out_ready_i);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign limit = (ncent_q < 7'(MaxCentres)) ? KW'(ncent_q) : KW'(MaxCentres);
  assign fprod = CW'(pcount_q) * 16'(rand_q);
  assign last_pt = (CW'(idx_q) == pcount_q - CW'(1));
  assign newd = (ddist < nd_rd_q) ? ddist : nd_rd_q;
  assign nsum = sum_q + SB'(nd_rd_q);

  always_comb begin
    state_d = state_q;
    pcount_d = pcount_q; ccount_d = ccount_q; last_d = last_q;
    idx_d = idx_q; total_d = total_q; sum_d = sum_q; target_d = target_q;
    rand_d = rand_q; ld_d = ld_q; pick_d = pick_q; first_pick_d = first_pick_q;
    ov_d = ov_q && !out_ready_i; st_d = st_q; ci_d = ci_q; cf_d = cf_q;
    we_pt = 1'b0; we_nd = 1'b0; wa_pt = pcount_q[AW-1:0]; wa_nd = idx_q;
    wd_pt = ld_q; wd_nd = DistMax; ra = idx_q; dreq.start = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          if (!op_i) begin
            // Capture the point; the write happens next cycle.
            for (int d = 0; d < Dims; d++) begin
              ld_d[d*FB +: FB] = (d < 4) ? fin[d][FB-1:0] : '0;
            end
            if (first_i) begin
              pcount_d = '0;
              ccount_d = '0;
            end
            state_d = StLoad;
          end else begin
            rand_d = rand_frac_i;
            st_d = kpp_pkg::StatusOk; ci_d = '0; cf_d = '0;
            if (pcount_q == '0) begin
              ov_d = 1'b1; st_d = kpp_pkg::StatusNoPoints;
            end else if (ccount_q >= limit) begin
              ov_d = 1'b1; st_d = kpp_pkg::StatusFull;
            end else if (ccount_q == '0) begin
              state_d = StFirst;
            end else begin
              idx_d = '0; total_d = '0;
              state_d = StRd1;
            end
          end
        end
      end
      StLoad: begin
        if (pcount_q != CW'(MaxPoints)) begin
          we_pt = 1'b1; we_nd = 1'b1; wa_nd = pcount_q[AW-1:0];
          pcount_d = pcount_q + CW'(1);
        end
        state_d = StIdle;
      end
      StFirst: begin
        pick_d = AW'(fprod[CW+15:16]);
        state_d = StFetch;
      end
      StRd1: begin
        // Read point and its distance; start the distance unit in the same cycle.
        state_d = StDist;
        dreq.start = 1'b1;
      end
      StDist: begin
        if (ddone) state_d = StUpd;
      end
      StUpd: begin
        we_nd = 1'b1; wd_nd = newd;
        total_d = total_q + SB'(newd);
        if (last_pt) begin
          state_d = StMul;
        end else begin
          idx_d = idx_q + AW'(1);
          state_d = StRd1;
        end
      end
      StMul: begin
        target_d = SB'(rand_q) * total_q;
        idx_d = '0; sum_d = '0;
        if (total_q == '0) begin
          pick_d = '0; state_d = StFetch;
        end else begin
          state_d = StRd2;
        end
      end
      StRd2: begin
        state_d = StCmp;
      end
      StCmp: begin
        sum_d = nsum;
        if (target_q <= (nsum << 16) || last_pt) begin
          pick_d = idx_q; state_d = StFetch;
        end else begin
          idx_d = idx_q + AW'(1); state_d = StRd2;
        end
      end
      StFetch: begin
        // pt_rd_q holds the chosen point after this read.
        ra = pick_q;
        if (ra == pick_q && first_pick_q) begin
          last_d = pt_rd_q;
          ccount_d = ccount_q + KW'(1);
          ov_d = 1'b1; st_d = kpp_pkg::StatusOk;
          ci_d = 10'(pick_q);
          for (int d = 0; d < 4; d++) begin
            cf_d[d*16 +: 16] = (d < Dims) ? 16'($signed(pt_rd_q[d*FB +: FB])) : '0;
          end
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
    first_pick_d = (state_d == StFetch) && (state_q == StFetch);
  end

  always_ff @(posedge clk_i) begin
    if (we_pt) pts_mem[wa_pt] <= wd_pt;
    if (we_nd) nd_mem[wa_nd] <= wd_nd;
    pt_rd_q <= pts_mem[ra];
    nd_rd_q <= nd_mem[ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      pcount_q <= '0;
      ccount_q <= '0;
      ncent_q <= 7'd1;
      last_q <= '0;
      ov_q <= 1'b0;
      first_pick_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pcount_q <= pcount_d;
      ccount_q <= ccount_d;
      last_q <= last_d;
      ov_q <= ov_d;
      first_pick_q <= first_pick_d;
      if (cfg_valid_i && cfg_ready_o) ncent_q <= cfg_num_centres_i;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d; total_q <= total_d; sum_q <= sum_d; target_q <= target_d;
    rand_q <= rand_d; ld_q <= ld_d; pick_q <= pick_d;
    st_q <= st_d; ci_q <= ci_d; cf_q <= cf_d;
  end

  assign out_valid_o    = ov_q;
  assign status_o       = st_q;
  assign chosen_index_o = ci_q;
  assign centre_f0_o    = cf_q[15:0];
  assign centre_f1_o    = cf_q[31:16];
  assign centre_f2_o    = cf_q[47:32];
  assign centre_f3_o    = cf_q[63:48];

`ifndef NO_ASSERTIONS
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pcount_q <= CW'(MaxPoints)) else $error("point count overflow");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !in_ready_o) else $error("ready while busy");
  a_ccnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ccount_q != $past(ccount_q) && ccount_q != '0) |-> ov_q)
    else $error("centre added without result");
`endif

endmodule
